[rtl/core/urtm_pkg.sv]
// shared types and constants for the ultrasonic ranging trimmed mean unit
package urtm_pkg;

  localparam int unsigned SAMPLE_COUNT = 5;
  localparam int unsigned PULSE_W      = 20;
  localparam int unsigned TRIG_W       = 8;
  localparam int unsigned DIST_W       = 23;
  localparam int unsigned CNT_W        = $clog2(SAMPLE_COUNT + 1);
  localparam int unsigned TOTAL_W      = PULSE_W + $clog2(SAMPLE_COUNT);
  localparam int unsigned TRIM_W       = PULSE_W + $clog2(SAMPLE_COUNT - 2);

  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 20;

  // distance = round(trim * SCALE / DIV), SCALE / 625 = 0.01715 * 256
  localparam int unsigned SCALE        = 2744;
  localparam int unsigned SCALE_W      = $clog2(SCALE + 1);
  localparam int unsigned DIV          = 625 * (SAMPLE_COUNT - 2);
  localparam int unsigned DIV_W        = $clog2(DIV);
  localparam int unsigned HALF         = DIV / 2;

  // quotient of trim by DIV
  localparam int unsigned K1           = TRIM_W + DIV_W;
  localparam int unsigned M1_W         = K1 - DIV_W + 1;
  localparam logic [M1_W-1:0] M1       = M1_W'(((64'd1 << K1) + 64'(DIV) - 64'd1) / 64'(DIV));
  localparam int unsigned A_W          = TRIM_W - DIV_W + 1;

  // rounded fraction of the remainder
  localparam longint unsigned Y_MAX    = 64'(DIV - 1) * 64'(SCALE) + 64'(HALF);
  localparam int unsigned Y_W          = $clog2(Y_MAX + 1);
  localparam int unsigned K2           = Y_W + DIV_W;
  localparam int unsigned M2_W         = Y_W + 1;
  localparam logic [M2_W-1:0] M2       = M2_W'(((64'd1 << K2) + 64'(DIV) - 64'd1) / 64'(DIV));

  localparam int unsigned DFULL_RAW_W  = A_W + SCALE_W + 1;
  localparam int unsigned DFULL_W      = (DFULL_RAW_W > DIST_W) ? DFULL_RAW_W : DIST_W + 1;
  localparam longint unsigned DIST_MAX = (64'd1 << DIST_W) - 64'd1;

  localparam int unsigned FIFO_DEPTH   = 8;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int unsigned CRED_W       = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TLOW  = 3'd1,
    PH_THIGH = 3'd2,
    PH_RISE  = 3'd3,
    PH_MEAS  = 3'd4,
    PH_GAP   = 3'd5
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT    = 2'd0,
    CFG_TRIG_HIGH  = 2'd1,
    CFG_TRIG_LOW   = 2'd2,
    CFG_SAMPLE_GAP = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic trigger_level;
    logic busy_res;
    logic distance_valid;
  } ctl_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [DIST_W-1:0] distance;
  } item_t;

endpackage

[rtl/core/urtm_ifs.sv]
// request and result channel interfaces
interface urtm_in_if;
  logic valid;
  logic ready;
  logic echo_level;
  logic start_request;

  modport source (output valid, echo_level, start_request, input ready);
  modport sink   (input valid, echo_level, start_request, output ready);
endinterface

interface urtm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       trigger_level;
  logic                       busy_res;
  logic                       distance_valid;
  logic [urtm_pkg::DIST_W-1:0] distance;

  modport source (output valid, trigger_level, busy_res, distance_valid, distance,
                  input ready);
  modport sink   (input valid, trigger_level, busy_res, distance_valid, distance,
                  output ready);
endinterface

[rtl/core/urtm_sort_cell.sv]
// one cell of the insertion sorter holding a pulse width
module urtm_sort_cell (
  input  logic                         clk,
  input  logic                         ins_en,
  input  logic                         occ,
  input  logic [urtm_pkg::PULSE_W-1:0] new_val,
  input  logic [urtm_pkg::PULSE_W-1:0] left_val,
  input  logic                         left_lt,
  output logic [urtm_pkg::PULSE_W-1:0] val,
  output logic                         lt
);

  logic [urtm_pkg::PULSE_W-1:0] val_r;
  logic [urtm_pkg::PULSE_W-1:0] val_nxt;

  // empty cells act as larger than anything
  assign lt  = occ ? (new_val < val_r) : 1'b1;
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ins_en && lt) begin
      val_nxt = left_lt ? left_val : new_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[rtl/core/urtm_scale.sv]
// pipeline turning the trimmed sum into a rounded distance
module urtm_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_v,
  input  urtm_pkg::ctl_t              in_ctl,
  input  logic [urtm_pkg::TRIM_W-1:0] in_trim,
  output logic                        out_v,
  output urtm_pkg::item_t             out_item
);

  logic [5:0] v_r;

  urtm_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  logic [urtm_pkg::TRIM_W-1:0] trim1_r, trim2_r;
  logic [urtm_pkg::A_W-1:0]    a2_r, a3_r, a4_r, a5_r;
  logic [urtm_pkg::DIV_W-1:0]  b3_r;
  logic [urtm_pkg::Y_W-1:0]    y4_r;
  logic [urtm_pkg::SCALE_W-1:0] c5_r;
  logic [urtm_pkg::DIST_W-1:0] last_r;
  urtm_pkg::item_t             item6_r;

  logic [urtm_pkg::TRIM_W+urtm_pkg::M1_W-1:0] p1;
  logic [urtm_pkg::TRIM_W-1:0]                ad;
  logic [urtm_pkg::Y_W+urtm_pkg::M2_W-1:0]    p2;
  logic [urtm_pkg::DFULL_W-1:0]               dist_full;
  logic [urtm_pkg::DIST_W-1:0]                dist_sat;

  assign p1 = (urtm_pkg::TRIM_W + urtm_pkg::M1_W)'(trim1_r) *
              (urtm_pkg::TRIM_W + urtm_pkg::M1_W)'(urtm_pkg::M1);
  assign ad = urtm_pkg::TRIM_W'(a2_r) * urtm_pkg::TRIM_W'(urtm_pkg::DIV);
  assign p2 = (urtm_pkg::Y_W + urtm_pkg::M2_W)'(y4_r) *
              (urtm_pkg::Y_W + urtm_pkg::M2_W)'(urtm_pkg::M2);
  assign dist_full = urtm_pkg::DFULL_W'(a5_r) * urtm_pkg::DFULL_W'(urtm_pkg::SCALE) +
                     urtm_pkg::DFULL_W'(c5_r);

  always_comb begin
    if (dist_full > urtm_pkg::DFULL_W'(urtm_pkg::DIST_MAX)) begin
      dist_sat = urtm_pkg::DIST_W'(urtm_pkg::DIST_MAX);
    end else begin
      dist_sat = urtm_pkg::DIST_W'(dist_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      last_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_v};
      if (v_r[4] && ctl5_r.distance_valid) begin
        last_r <= dist_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    ctl1_r  <= in_ctl;
    trim1_r <= in_trim;

    ctl2_r  <= ctl1_r;
    trim2_r <= trim1_r;
    a2_r    <= p1[urtm_pkg::K1 +: urtm_pkg::A_W];

    ctl3_r  <= ctl2_r;
    a3_r    <= a2_r;
    b3_r    <= urtm_pkg::DIV_W'(trim2_r - ad);

    ctl4_r  <= ctl3_r;
    a4_r    <= a3_r;
    y4_r    <= urtm_pkg::Y_W'(b3_r) * urtm_pkg::Y_W'(urtm_pkg::SCALE) +
               urtm_pkg::Y_W'(urtm_pkg::HALF);

    ctl5_r  <= ctl4_r;
    a5_r    <= a4_r;
    c5_r    <= p2[urtm_pkg::K2 +: urtm_pkg::SCALE_W];

    item6_r.ctl      <= ctl5_r;
    item6_r.distance <= ctl5_r.distance_valid ? dist_sat : last_r;
  end

  assign out_v    = v_r[5];
  assign out_item = item6_r;

endmodule

[rtl/core/urtm_out_fifo.sv]
// result queue feeding the output channel
module urtm_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  urtm_pkg::item_t wr_item,
  urtm_out_if.source      out_ch
);

  urtm_pkg::item_t mem_r [urtm_pkg::FIFO_DEPTH];

  logic [urtm_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [urtm_pkg::CRED_W-1:0]  count_r;
  logic                         rd_en;
  urtm_pkg::item_t              rd_item;

  assign rd_en   = out_ch.valid && out_ch.ready;
  assign rd_item = mem_r[rd_ptr_r];

  assign out_ch.valid          = count_r != '0;
  assign out_ch.trigger_level  = rd_item.ctl.trigger_level;
  assign out_ch.busy_res       = rd_item.ctl.busy_res;
  assign out_ch.distance_valid = rd_item.ctl.distance_valid;
  assign out_ch.distance       = rd_item.distance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= urtm_pkg::FIFO_AW'(wr_ptr_r + 1'b1);
      end
      if (rd_en) begin
        rd_ptr_r <= urtm_pkg::FIFO_AW'(rd_ptr_r + 1'b1);
      end
      count_r <= urtm_pkg::CRED_W'(count_r + urtm_pkg::CRED_W'(wr_en) -
                                   urtm_pkg::CRED_W'(rd_en));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

[rtl/core/ultrasonic_ranging_trimmed_mean_unit.sv]
// top level: echo ranging sequencer, sorter chain, distance pipeline and result queue
//
// One request is one microsecond tick (echo level and start request) and gives
// exactly one result (trigger level, busy, distance valid, distance). A request
// is taken every cycle that ready is high; its result waits in the queue until taken.
// The sequencer, the row of sorter cells and the running total advance once per
// request, and the distance math runs in a six-stage pipeline behind them. in_ch
// drops ready only once eight requests are outstanding, which is the depth of
// the output queue, so a stalled result side stops the input after eight requests.
// Configuration writes take effect on the next tick.
module ultrasonic_ranging_trimmed_mean_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  urtm_in_if.sink                         in_ch,
  urtm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [urtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urtm_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [urtm_pkg::PULSE_W-1:0] timeout_r;
  logic [urtm_pkg::TRIG_W-1:0]  trig_high_r;
  logic [urtm_pkg::TRIG_W-1:0]  trig_low_r;
  logic [urtm_pkg::PULSE_W-1:0] gap_r;

  urtm_pkg::phase_t             phase_r, phase_nxt;
  logic [urtm_pkg::PULSE_W-1:0] timer_r, timer_nxt, timer_p1;
  logic [urtm_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [urtm_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [urtm_pkg::CRED_W-1:0]  cred_r;

  logic acc, deq, echo, full, gap_end;
  logic trig, store_en, done, start_go;

  logic [urtm_pkg::PULSE_W-1:0] cell_val  [urtm_pkg::SAMPLE_COUNT];
  logic                         cell_lt   [urtm_pkg::SAMPLE_COUNT];
  logic [urtm_pkg::PULSE_W-1:0] left_val  [urtm_pkg::SAMPLE_COUNT];
  logic                         left_lt   [urtm_pkg::SAMPLE_COUNT];
  logic                         cell_occ  [urtm_pkg::SAMPLE_COUNT];

  urtm_pkg::ctl_t               pipe_ctl;
  logic [urtm_pkg::TRIM_W-1:0]  pipe_trim;
  logic                         res_v;
  urtm_pkg::item_t              res_item;

  assign acc      = in_ch.valid && in_ch.ready;
  assign deq      = out_ch.valid && out_ch.ready;
  assign in_ch.ready = cred_r < urtm_pkg::CRED_W'(urtm_pkg::FIFO_DEPTH);
  assign echo     = in_ch.echo_level;
  assign timer_p1 = urtm_pkg::PULSE_W'(timer_r + 1'b1);
  assign full     = count_r >= urtm_pkg::CNT_W'(urtm_pkg::SAMPLE_COUNT);
  assign gap_end  = timer_p1 >= gap_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= urtm_pkg::PULSE_W'(500000);
      trig_high_r <= urtm_pkg::TRIG_W'(10);
      trig_low_r  <= urtm_pkg::TRIG_W'(2);
      gap_r       <= urtm_pkg::PULSE_W'(10000);
    end else if (cfg_we) begin
      unique case (urtm_pkg::cfg_reg_t'(cfg_index))
        urtm_pkg::CFG_TIMEOUT:    timeout_r   <= cfg_data;
        urtm_pkg::CFG_TRIG_HIGH:  trig_high_r <= cfg_data[urtm_pkg::TRIG_W-1:0];
        urtm_pkg::CFG_TRIG_LOW:   trig_low_r  <= cfg_data[urtm_pkg::TRIG_W-1:0];
        urtm_pkg::CFG_SAMPLE_GAP: gap_r       <= cfg_data;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    unique case (phase_r)
      urtm_pkg::PH_TLOW: begin
        timer_nxt = timer_p1;
        if (timer_p1 >= urtm_pkg::PULSE_W'(trig_low_r)) begin
          phase_nxt = urtm_pkg::PH_THIGH;
          timer_nxt = '0;
        end
      end
      urtm_pkg::PH_THIGH: begin
        timer_nxt = timer_p1;
        if (timer_p1 >= urtm_pkg::PULSE_W'(trig_high_r)) begin
          phase_nxt = urtm_pkg::PH_RISE;
          timer_nxt = '0;
        end
      end
      urtm_pkg::PH_RISE: begin
        priority if (echo) begin
          if (timeout_r == '0) begin
            phase_nxt = urtm_pkg::PH_GAP;
            timer_nxt = '0;
          end else begin
            phase_nxt = urtm_pkg::PH_MEAS;
            timer_nxt = urtm_pkg::PULSE_W'(1);
          end
        end else if (timer_r >= timeout_r) begin
          phase_nxt = urtm_pkg::PH_GAP;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_p1;
        end
      end
      urtm_pkg::PH_MEAS: begin
        if (echo && timer_r < timeout_r) begin
          timer_nxt = timer_p1;
        end else begin
          phase_nxt = urtm_pkg::PH_GAP;
          timer_nxt = '0;
        end
      end
      urtm_pkg::PH_GAP: begin
        timer_nxt = timer_p1;
        if (gap_end) begin
          timer_nxt = '0;
          if (full) begin
            phase_nxt = urtm_pkg::PH_IDLE;
          end else if (trig_low_r == '0) begin
            phase_nxt = urtm_pkg::PH_THIGH;
          end else begin
            phase_nxt = urtm_pkg::PH_TLOW;
          end
        end
      end
      default: begin
        phase_nxt = urtm_pkg::PH_IDLE;
        if (in_ch.start_request) begin
          timer_nxt = '0;
          phase_nxt = (trig_low_r == '0) ? urtm_pkg::PH_THIGH : urtm_pkg::PH_TLOW;
        end
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    trig     = 1'b0;
    store_en = 1'b0;
    done     = 1'b0;
    start_go = 1'b0;
    unique case (phase_r)
      urtm_pkg::PH_TLOW, urtm_pkg::PH_RISE: ;
      urtm_pkg::PH_THIGH: trig = 1'b1;
      urtm_pkg::PH_MEAS: store_en = acc && !echo && !full;
      urtm_pkg::PH_GAP:  done = gap_end && full;
      default:           start_go = acc && in_ch.start_request;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    priority if (start_go) begin
      count_nxt = '0;
      total_nxt = '0;
    end else if (store_en) begin
      count_nxt = urtm_pkg::CNT_W'(count_r + 1'b1);
      total_nxt = urtm_pkg::TOTAL_W'(total_r + urtm_pkg::TOTAL_W'(timer_r));
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urtm_pkg::PH_IDLE;
      timer_r <= '0;
      count_r <= '0;
      cred_r  <= '0;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt;
        timer_r <= timer_nxt;
        count_r <= count_nxt;
      end
      cred_r <= urtm_pkg::CRED_W'(cred_r + urtm_pkg::CRED_W'(acc) - urtm_pkg::CRED_W'(deq));
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      total_r <= total_nxt;
    end
  end

  // sorter chain, kept ascending
  for (genvar g = 0; g < urtm_pkg::SAMPLE_COUNT; g++) begin : g_cell
    assign cell_occ[g] = urtm_pkg::CNT_W'(g) < count_r;
    if (g == 0) begin : g_head
      assign left_val[g] = timer_r;
      assign left_lt[g]  = 1'b0;
    end else begin : g_link
      assign left_val[g] = cell_val[g-1];
      assign left_lt[g]  = cell_lt[g-1];
    end

    urtm_sort_cell u_cell (
      .clk      (clk),
      .ins_en   (store_en),
      .occ      (cell_occ[g]),
      .new_val  (timer_r),
      .left_val (left_val[g]),
      .left_lt  (left_lt[g]),
      .val      (cell_val[g]),
      .lt       (cell_lt[g])
    );
  end

  // drop min and max
  assign pipe_trim = urtm_pkg::TRIM_W'(total_r
                     - urtm_pkg::TOTAL_W'(cell_val[0])
                     - urtm_pkg::TOTAL_W'(cell_val[urtm_pkg::SAMPLE_COUNT-1]));

  assign pipe_ctl.trigger_level  = trig;
  assign pipe_ctl.busy_res       = phase_nxt != urtm_pkg::PH_IDLE;
  assign pipe_ctl.distance_valid = done;

  urtm_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (acc),
    .in_ctl   (pipe_ctl),
    .in_trim  (pipe_trim),
    .out_v    (res_v),
    .out_item (res_item)
  );

  urtm_out_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_v),
    .wr_item (res_item),
    .out_ch  (out_ch)
  );

endmodule

[bench/tb_ultrasonic_ranging_trimmed_mean_unit.sv]
// self-checking testbench: directed and random echo ticks through the ranging unit, results checked per tick
module tb_ultrasonic_ranging_trimmed_mean_unit;
  import urtm_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam longint unsigned CM_SCALE = 2744;
  localparam longint unsigned MEAN_DIV = 625 * (SAMPLE_COUNT - 2);
  localparam longint unsigned DIST_TOP = (64'd1 << DIST_W) - 64'd1;
  localparam int unsigned WIDX_W       = $clog2(SAMPLE_COUNT);

  typedef struct packed {
    logic echo;
    logic start;
  } tick_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  urtm_in_if  in_ch ();
  urtm_out_if out_ch ();

  ultrasonic_ranging_trimmed_mean_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  tick_t queued_ticks[$];
  item_t expected_readings[$];
  int ticks_queued = 0;
  int ticks_accepted = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic tick_taken = 1'b0;
  logic sink_hold = 1'b0;
  logic pressure_go = 1'b0;
  int echo_run = 0;
  logic echo_high = 1'b0;

  // shadow registers and ranger state
  logic [PULSE_W-1:0] timeout_reg;
  logic [TRIG_W-1:0]  trig_high_reg;
  logic [TRIG_W-1:0]  trig_low_reg;
  logic [PULSE_W-1:0] gap_reg;
  phase_t             rng_phase;
  logic [PULSE_W-1:0] rng_timer;
  logic [PULSE_W-1:0] widths [SAMPLE_COUNT];
  int                 width_count;
  logic [DIST_W-1:0]  held_distance;

  function automatic void begin_ping();
    rng_timer = '0;
    rng_phase = (trig_low_reg == 0) ? PH_THIGH : PH_TLOW;
  endfunction

  function automatic logic [DIST_W-1:0] trimmed_distance();
    longint unsigned total, lo, hi, rounded;
    total = 0;
    lo = 64'hFFFFF;
    hi = 0;
    for (int k = 0; k < SAMPLE_COUNT; k++) begin
      total += 64'(widths[WIDX_W'(k)]);
      if (64'(widths[WIDX_W'(k)]) < lo) lo = 64'(widths[WIDX_W'(k)]);
      if (64'(widths[WIDX_W'(k)]) > hi) hi = 64'(widths[WIDX_W'(k)]);
    end
    rounded = ((total - lo - hi) * CM_SCALE + MEAN_DIV / 2) / MEAN_DIV;
    if (rounded > DIST_TOP) rounded = DIST_TOP;
    return rounded[DIST_W-1:0];
  endfunction

  function automatic item_t ranger_step(logic echo, logic start);
    item_t res;
    logic trig, fresh;
    trig = 1'b0;
    fresh = 1'b0;
    case (rng_phase)
      PH_TLOW: begin
        rng_timer = rng_timer + 1'b1;
        if (rng_timer >= trig_low_reg) begin
          rng_phase = PH_THIGH;
          rng_timer = '0;
        end
      end
      PH_THIGH: begin
        trig = 1'b1;
        rng_timer = rng_timer + 1'b1;
        if (rng_timer >= trig_high_reg) begin
          rng_phase = PH_RISE;
          rng_timer = '0;
        end
      end
      PH_RISE: begin
        if (echo) begin
          if (timeout_reg == 0) begin
            rng_phase = PH_GAP;
            rng_timer = '0;
          end else begin
            rng_phase = PH_MEAS;
            rng_timer = PULSE_W'(1);
          end
        end else if (rng_timer >= timeout_reg) begin
          rng_phase = PH_GAP;
          rng_timer = '0;
        end else begin
          rng_timer = rng_timer + 1'b1;
        end
      end
      PH_MEAS: begin
        if (echo) begin
          if (rng_timer >= timeout_reg) begin
            rng_phase = PH_GAP;
            rng_timer = '0;
          end else begin
            rng_timer = rng_timer + 1'b1;
          end
        end else begin
          if (width_count < SAMPLE_COUNT) begin
            widths[WIDX_W'(width_count)] = rng_timer;
            width_count++;
          end
          rng_phase = PH_GAP;
          rng_timer = '0;
        end
      end
      PH_GAP: begin
        rng_timer = rng_timer + 1'b1;
        if (rng_timer >= gap_reg) begin
          if (width_count >= SAMPLE_COUNT) begin
            held_distance = trimmed_distance();
            fresh = 1'b1;
            rng_phase = PH_IDLE;
            rng_timer = '0;
          end else begin
            begin_ping();
          end
        end
      end
      default: begin
        rng_phase = PH_IDLE;
        if (start) begin
          width_count = 0;
          begin_ping();
        end
      end
    endcase
    res.ctl.trigger_level = trig;
    res.ctl.busy_res = (rng_phase != PH_IDLE);
    res.ctl.distance_valid = fresh;
    res.distance = held_distance;
    return res;
  endfunction

  task automatic report_mismatch(string what, item_t want, item_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): expected trig=%b busy=%b dv=%b dist=%0d,",
                " got trig=%b busy=%b dv=%b dist=%0d"},
               what, want.ctl.trigger_level, want.ctl.busy_res, want.ctl.distance_valid,
               want.distance, seen.ctl.trigger_level, seen.ctl.busy_res,
               seen.ctl.distance_valid, seen.distance);
  endtask

  // request driver
  always @(negedge clk) begin
    tick_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || tick_taken) begin
      if (queued_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = queued_ticks.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.echo_level <= nxt.echo;
        in_ch.start_request <= nxt.start;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !sink_hold && ($urandom_range(99) >= stall_pct);
  end

  // monitor and checker
  always @(posedge clk) begin
    item_t seen, want;
    if (!rst_n) begin
      tick_taken <= 1'b0;
      timeout_reg = 20'd500000;
      trig_high_reg = 8'd10;
      trig_low_reg = 8'd2;
      gap_reg = 20'd10000;
      rng_phase = PH_IDLE;
      rng_timer = '0;
      for (int k = 0; k < SAMPLE_COUNT; k++) widths[WIDX_W'(k)] = '0;
      width_count = 0;
      held_distance = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT:    timeout_reg = cfg_data;
          CFG_TRIG_HIGH:  trig_high_reg = cfg_data[TRIG_W-1:0];
          CFG_TRIG_LOW:   trig_low_reg = cfg_data[TRIG_W-1:0];
          CFG_SAMPLE_GAP: gap_reg = cfg_data;
          default: ;
        endcase
      end
      tick_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        expected_readings.push_back(ranger_step(in_ch.echo_level, in_ch.start_request));
        ticks_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.ctl.trigger_level = out_ch.trigger_level;
        seen.ctl.busy_res = out_ch.busy_res;
        seen.ctl.distance_valid = out_ch.distance_valid;
        seen.distance = out_ch.distance;
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected", '0, seen);
        end else begin
          want = expected_readings.pop_front();
          if (seen.ctl.trigger_level !== want.ctl.trigger_level ||
              seen.ctl.busy_res !== want.ctl.busy_res ||
              seen.ctl.distance_valid !== want.ctl.distance_valid ||
              seen.distance !== want.distance)
            report_mismatch("field", want, seen);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // long result-side hold while requests keep coming
  initial begin
    wait (pressure_go);
    @(negedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    sink_hold <= 1'b0;
  end

  task automatic queue_tick(logic echo, logic start);
    queued_ticks.push_back('{echo: echo, start: start});
    ticks_queued++;
  endtask

  // echo waveform of random pulses, with some noise ticks
  task automatic queue_random(int count, int rise_max, int high_max);
    logic e;
    for (int i = 0; i < count; i++) begin
      if (echo_run == 0) begin
        echo_high = !echo_high;
        echo_run = echo_high ? $urandom_range(high_max, 1) : $urandom_range(rise_max, 1);
      end
      echo_run--;
      e = ($urandom_range(15) == 0) ? 1'($urandom_range(1)) : echo_high;
      queue_tick(e, $urandom_range(7) == 0);
    end
  endtask

  task automatic program_ranger(logic [CFG_DATA_W-1:0] tmo, logic [CFG_DATA_W-1:0] thi,
                                logic [CFG_DATA_W-1:0] tlo, logic [CFG_DATA_W-1:0] gap);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data <= tmo;
    @(negedge clk);
    cfg_index <= CFG_TRIG_HIGH;
    cfg_data <= thi;
    @(negedge clk);
    cfg_index <= CFG_TRIG_LOW;
    cfg_data <= tlo;
    @(negedge clk);
    cfg_index <= CFG_SAMPLE_GAP;
    cfg_data <= gap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pace(int idle, int stall);
    send_idle_pct <= idle;
    stall_pct <= stall;
  endtask

  task automatic drain();
    while (ticks_accepted != ticks_queued || expected_readings.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [4:0]  zero_echo, zero_start;
    logic [23:0] short_echo, short_start;
    zero_echo = 5'b10110;
    zero_start = 5'b01100;
    short_echo = 24'b111000100011000100011000;
    short_start = 24'b100000000000000000000000;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TIMEOUT;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.echo_level = 1'b0;
    in_ch.start_request = 1'b0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero timeout, zero trigger widths, start while busy
    set_pace(0, 0);
    program_ranger(20'd0, 20'd0, 20'd0, 20'd0);
    for (int i = 4; i >= 0; i--) queue_tick(zero_echo[3'(i)], zero_start[3'(i)]);
    drain();

    // five short pulses to one distance, trigger high write with upper bits set
    program_ranger(20'd2, 20'hFFF01, 20'd0, 20'd0);
    for (int i = 23; i >= 0; i--) queue_tick(short_echo[5'(i)], short_start[5'(i)]);
    drain();

    program_ranger(20'd24, 20'd2, 20'd1, 20'd3);
    queue_random(450, 14, 20);
    drain();

    set_pace(63, 0);
    program_ranger(20'd1, 20'd255, 20'd255, 20'd0);
    queue_random(250, 4, 2);
    drain();

    set_pace(0, 63);
    program_ranger(20'hFFFFF, 20'd1, 20'd0, 20'd2);
    queue_random(450, 8, 10);
    drain();

    set_pace(37, 37);
    program_ranger(20'd16, 20'd3, 20'd2, 20'hFFFFF);
    queue_random(40, 6, 8);
    drain();

    set_pace(0, 0);
    program_ranger(20'd20, 20'd1, 20'd1, 20'd1);
    pressure_go <= 1'b1;
    queue_random(500, 12, 24);
    drain();

    set_pace(37, 37);
    program_ranger(20'd30, 20'd4, 20'd3, 20'd5);
    queue_random(450, 20, 34);
    drain();

    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_readings.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
rtl/core/urtm_pkg.sv
rtl/core/urtm_ifs.sv
rtl/core/urtm_sort_cell.sv
rtl/core/urtm_scale.sv
rtl/core/urtm_out_fifo.sv
rtl/core/ultrasonic_ranging_trimmed_mean_unit.sv
bench/tb_ultrasonic_ranging_trimmed_mean_unit.sv
